/* rtl/sact_pkg.sv */
package sact_pkg;

  // Default geometry (sets and block size are powers of two)
  localparam int unsigned WaysDef       = 4;
  localparam int unsigned SetsDef       = 64;
  localparam int unsigned BlockBytesDef = 32;

  // Access operations
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

/* rtl/sact_ram.sv */
module sact_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/set_assoc_cache_tag_store.sv */
// Tag store of a set-associative, write-through, no-write-allocate data cache. Each item is a
// read, write or flush; the result tells whether the access completed (accepted), hit, or
// crossed a block boundary (unaligned, nothing changed). Sets are kept in age order; in LRU
// mode a read hit moves its way to the front, in FIFO mode only a read fill does, and a fill
// drops the oldest way. One item per cycle is sustained unless the result channel stalls: the set
// is read from a single synchronous RAM in the cycle of acceptance and compared and written back
// in the lookup state that follows, with the written set forwarded when the following item reads
// the same set. After reset and after every flush the block runs a clearing pass over all SETS
// sets (one set per cycle) during which it takes no item.
// SETS and BLOCK_BYTES must be powers of two.
module set_assoc_cache_tag_store import sact_pkg::*; #(
  parameter int unsigned WAYS        = WaysDef,
  parameter int unsigned SETS        = SetsDef,
  parameter int unsigned BLOCK_BYTES = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_replace_lru_i,
  // access channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] address_i,
  input  logic [2:0]  size_i,
  input  logic        mem_ready_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        hit_o,
  output logic        unaligned_o
);

  localparam int unsigned OffW  = $clog2(BLOCK_BYTES);
  localparam int unsigned SetB  = $clog2(SETS);
  localparam int unsigned SetW  = (SetB > 0) ? SetB : 1;
  localparam int unsigned TagW  = 32 - OffW - SetB;
  localparam int unsigned EntW  = TagW + 1;
  localparam int unsigned LineW = WAYS * EntW;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SumW  = OffW + 4;

  state_e state_q, state_d;

  logic             lru_q;
  logic [1:0]       op_q;
  logic [TagW-1:0]  tag_q;
  logic [SetW-1:0]  set_q;
  logic             cross_q;
  logic             ready_q;
  logic             fwd_sel_q, fwd_sel_d;
  logic [LineW-1:0] fwd_line_q;
  logic [SetW-1:0]  clr_q, clr_d;
  logic             clr_last;

  logic             out_valid_q, out_valid_d;
  logic             acc_q, hit_q, unal_q;

  logic             accept;
  logic             done;
  logic [SetW-1:0]  set_in;
  logic [TagW-1:0]  tag_in;
  logic [OffW-1:0]  off_in;
  logic             cross_in;

  logic [LineW-1:0] ram_rdata;
  logic             ram_we;
  logic [SetW-1:0]  ram_waddr;
  logic [LineW-1:0] ram_wdata;

  logic [LineW-1:0] line;
  logic [LineW-1:0] line_sh;
  logic [LineW-1:0] new_line;
  logic [WAYS-1:0]  hit_vec;
  logic             any_hit;
  logic [WayW-1:0]  hit_way;
  logic [WayW-1:0]  last_way;
  logic             lk_we;
  logic             lk_acc, lk_hit, lk_unal;

  // Address split and block crossing check on the incoming item
  assign off_in   = address_i[OffW-1:0];
  assign set_in   = (SetB > 0) ? SetW'(address_i >> OffW) : '0;
  assign tag_in   = TagW'(address_i >> (OffW + SetB));
  assign cross_in = (SumW'(off_in) + SumW'(size_i)) > SumW'(BLOCK_BYTES);

  // Handshake
  assign done       = (state_q == ST_LOOKUP) && !(out_valid_q && out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || (done && (op_q != OP_FLUSH)));
  assign accept     = in_valid_i && !in_stall_o;
  assign clr_last   = (clr_q == SetW'(SETS - 1));

  // Set read in the lookup cycle, forwarded when the last write hit the same set
  assign line    = fwd_sel_q ? fwd_line_q : ram_rdata;
  assign line_sh = LineW'({line, EntW'(0)});

  // Way compare
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = line[i*EntW + TagW] && (line[i*EntW +: TagW] == tag_q);
    end
  end

  // First matching way
  always_comb begin
    hit_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WayW'(i);
      end
    end
  end

  assign any_hit  = |hit_vec;
  assign last_way = any_hit ? hit_way : WayW'(WAYS - 1);

  // Move to front: younger ways up to last_way age by one, block enters way 0
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (i == 0) begin
        new_line[i*EntW +: EntW] = {1'b1, tag_q};
      end else if (WayW'(i) <= last_way) begin
        new_line[i*EntW +: EntW] = line_sh[i*EntW +: EntW];
      end else begin
        new_line[i*EntW +: EntW] = line[i*EntW +: EntW];
      end
    end
  end

  // Outcome of the access under lookup
  always_comb begin
    lk_we   = 1'b0;
    lk_acc  = 1'b1;
    lk_hit  = 1'b0;
    lk_unal = 1'b0;
    case (op_q)
      OP_READ: begin
        if (cross_q) begin
          lk_unal = 1'b1;
        end else if (any_hit) begin
          lk_hit = 1'b1;
          lk_we  = lru_q;
        end else if (ready_q) begin
          lk_we = 1'b1;
        end else begin
          lk_acc = 1'b0;
        end
      end
      OP_WRITE: begin
        if (cross_q) begin
          lk_unal = 1'b1;
        end else if (ready_q) begin
          lk_hit = any_hit;
        end else begin
          lk_acc = 1'b0;
        end
      end
      default: begin
        lk_acc = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          if (op_q == OP_FLUSH) begin
            state_d = ST_CLEAR;
          end else if (accept) begin
            state_d = ST_LOOKUP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // RAM write, clear counter and forwarding control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = new_line;
    clr_d     = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_last ? '0 : clr_q + SetW'(1);
      end
      ST_LOOKUP: begin
        ram_we = done && lk_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    fwd_sel_d = ram_we && (state_q == ST_LOOKUP) && (set_in == set_q);
  end

  assign out_valid_d = done ? 1'b1 : (out_valid_q && out_stall_i);

  sact_ram #(
    .WIDTH (LineW),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_in),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lru_q       <= 1'b1;
      out_valid_q <= 1'b0;
      fwd_sel_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lru_q <= cfg_replace_lru_i;
      end
      if (accept) begin
        fwd_sel_q <= fwd_sel_d;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_i;
      tag_q      <= tag_in;
      set_q      <= set_in;
      cross_q    <= cross_in;
      ready_q    <= mem_ready_i;
      fwd_line_q <= new_line;
    end
    if (done) begin
      acc_q  <= lk_acc;
      hit_q  <= lk_hit;
      unal_q <= lk_unal;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = acc_q;
  assign hit_o       = hit_q;
  assign unaligned_o = unal_q;

endmodule
